// File: hdl/pbd_pkg.sv
// shared types and constants for the pci bar decoder
package pbd_pkg;

   localparam int unsigned NUM_SLOTS = 6;

   localparam logic [31:0] IO_BIT         = 32'h0000_0001;
   localparam logic [31:0] MEM_TYPE_FIELD = 32'h0000_0006;
   localparam logic [31:0] MEM_TYPE_64    = 32'h0000_0004;
   localparam logic [31:0] PREFETCH_BIT   = 32'h0000_0008;
   localparam logic [31:0] IO_ADDR_BITS   = 32'hFFFF_FFFC;
   localparam logic [31:0] MEM_ADDR_BITS  = 32'hFFFF_FFF0;
   localparam logic [31:0] IO_UPPER_HALF  = 32'hFFFF_0000;

   localparam logic [63:0] IO_MIN_SIZE  = 64'd4;
   localparam logic [63:0] MEM_MIN_SIZE = 64'd16;

   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_BAD_INDEX     = 3'd1;
   localparam logic [2:0] ST_UNSUPPORTED   = 3'd2;
   localparam logic [2:0] ST_UNIMPLEMENTED = 3'd3;
   localparam logic [2:0] ST_BAD_SIZE      = 3'd4;
   localparam logic [2:0] ST_UNASSIGNED    = 3'd5;
   localparam logic [2:0] ST_MISALIGNED    = 3'd6;

   localparam logic [1:0] KIND_IO    = 2'd0;
   localparam logic [1:0] KIND_MEM32 = 2'd1;
   localparam logic [1:0] KIND_MEM64 = 2'd2;

   typedef struct packed {
      logic [2:0]  bar_index;
      logic [31:0] orig_low;
      logic [31:0] orig_high;
      logic [31:0] probed_low;
      logic [31:0] probed_high;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  region_kind;
      logic        prefetch;
      logic [1:0]  slots_used;
      logic [63:0] base_address;
      logic [63:0] region_size;
   } rsp_type;

   // after classification
   typedef struct packed {
      logic        valid;
      logic [2:0]  status;
      logic [1:0]  kind;
      logic        prefetch;
      logic [1:0]  slots;
      logic [63:0] mask;
      logic [63:0] base;
   } stage1_type;

   // after size formation
   typedef struct packed {
      logic        valid;
      logic [2:0]  status;
      logic [1:0]  kind;
      logic        prefetch;
      logic [1:0]  slots;
      logic [63:0] size;
      logic [63:0] base;
   } stage2_type;

endpackage

// File: hdl/pci_bar_decode_top.sv
// top level of the pci base address register decoder
// an accepted item passes the classify, size and result registers before its result strobes
// throughput: one item per cycle, busy never rises
// stages: classify, size negate (64-bit add), checks into the result register
// reset: synchronous, clears the stage valid bits, so no strobe follows reset
// the receiver cannot stall, so the pipeline never holds
module pci_bar_decode_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pbd_pkg::req_type req_item,
   output logic             rsp_valid,
   output pbd_pkg::rsp_type rsp_item
);

   pbd_pkg::stage1_type s1;
   pbd_pkg::stage2_type s2;
   logic                accept;

   // every cycle takes a new item
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // type bits, mask and base, early index and type errors
   pbd_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_item),
      .out_stage (s1)
   );

   // size formed as two's complement of the mask, zero mask flagged
   pbd_size u_size (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (s1),
      .out_stage (s2)
   );

   // remaining checks in priority order, fields zeroed on error
   pbd_check u_check (
      .clock     (clock),
      .reset     (reset),
      .in_stage  (s2),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

endmodule

// File: hdl/pbd_classify.sv
// stage one: slot type classification, mask and base extraction
module pbd_classify (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  pbd_pkg::req_type in_item,
   output pbd_pkg::stage1_type out_stage
);

   pbd_pkg::stage1_type stage_ff;
   pbd_pkg::stage1_type stage_in;
   logic [31:0]         io_mask;
   logic [31:0]         mem_type;

   always_comb begin
      stage_in          = '0;
      stage_in.valid    = in_valid;
      stage_in.status   = pbd_pkg::ST_OK;
      stage_in.slots    = 2'd1;
      io_mask           = in_item.probed_low & pbd_pkg::IO_ADDR_BITS;
      mem_type          = in_item.orig_low & pbd_pkg::MEM_TYPE_FIELD;
      // 16-bit io decoder: upper half forced on
      if ((io_mask & pbd_pkg::IO_UPPER_HALF) == 32'd0) begin
         io_mask = io_mask | pbd_pkg::IO_UPPER_HALF;
      end
      if (32'(in_item.bar_index) >= pbd_pkg::NUM_SLOTS) begin
         stage_in.status = pbd_pkg::ST_BAD_INDEX;
      end else if ((in_item.orig_low & pbd_pkg::IO_BIT) != 32'd0) begin
         stage_in.kind = pbd_pkg::KIND_IO;
         stage_in.mask = {32'd0, io_mask};
         stage_in.base = {32'd0, in_item.orig_low & pbd_pkg::IO_ADDR_BITS};
      end else begin
         stage_in.prefetch = (in_item.orig_low & pbd_pkg::PREFETCH_BIT) != 32'd0;
         if (mem_type == 32'd0) begin
            stage_in.kind = pbd_pkg::KIND_MEM32;
            stage_in.mask = {32'd0, in_item.probed_low & pbd_pkg::MEM_ADDR_BITS};
            stage_in.base = {32'd0, in_item.orig_low & pbd_pkg::MEM_ADDR_BITS};
         end else if (mem_type == pbd_pkg::MEM_TYPE_64 &&
                      32'(in_item.bar_index) + 32'd1 < pbd_pkg::NUM_SLOTS) begin
            stage_in.kind  = pbd_pkg::KIND_MEM64;
            stage_in.slots = 2'd2;
            stage_in.mask  = {in_item.probed_high,
                              in_item.probed_low & pbd_pkg::MEM_ADDR_BITS};
            stage_in.base  = {in_item.orig_high,
                              in_item.orig_low & pbd_pkg::MEM_ADDR_BITS};
         end else begin
            stage_in.status = pbd_pkg::ST_UNSUPPORTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

// File: hdl/pbd_size.sv
// stage two: region size as two's complement of the mask
module pbd_size (
   input  logic                clock,
   input  logic                reset,
   input  pbd_pkg::stage1_type in_stage,
   output pbd_pkg::stage2_type out_stage
);

   pbd_pkg::stage2_type stage_ff;
   pbd_pkg::stage2_type stage_in;
   logic [63:0]         neg64;
   logic [31:0]         neg32;

   always_comb begin
      neg64             = (~in_stage.mask) + 64'd1;
      neg32             = (~in_stage.mask[31:0]) + 32'd1;
      stage_in.valid    = in_stage.valid;
      stage_in.status   = in_stage.status;
      stage_in.kind     = in_stage.kind;
      stage_in.prefetch = in_stage.prefetch;
      stage_in.slots    = in_stage.slots;
      stage_in.base     = in_stage.base;
      stage_in.size     = (in_stage.kind == pbd_pkg::KIND_MEM64) ? neg64 : {32'd0, neg32};
      if (in_stage.status == pbd_pkg::ST_OK && in_stage.mask == 64'd0) begin
         stage_in.status = pbd_pkg::ST_UNIMPLEMENTED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

// File: hdl/pbd_check.sv
// stage three: size, assignment and alignment checks, result register
module pbd_check (
   input  logic                clock,
   input  logic                reset,
   input  pbd_pkg::stage2_type in_stage,
   output logic                out_valid,
   output pbd_pkg::rsp_type    out_item
);

   logic             valid_ff;
   pbd_pkg::rsp_type item_ff;
   pbd_pkg::rsp_type item_in;
   logic [63:0]      size_m1;
   logic [2:0]       status;
   logic             single_bit;
   logic             too_small;

   always_comb begin
      size_m1    = in_stage.size - 64'd1;
      single_bit = (in_stage.size != 64'd0) && ((in_stage.size & size_m1) == 64'd0);
      too_small  = (in_stage.kind == pbd_pkg::KIND_IO) ?
                   (in_stage.size < pbd_pkg::IO_MIN_SIZE) :
                   (in_stage.size < pbd_pkg::MEM_MIN_SIZE);
      status     = in_stage.status;
      if (status == pbd_pkg::ST_OK) begin
         if (!single_bit || too_small) begin
            status = pbd_pkg::ST_BAD_SIZE;
         end else if (in_stage.base == 64'd0) begin
            status = pbd_pkg::ST_UNASSIGNED;
         end else if ((in_stage.base & size_m1) != 64'd0) begin
            status = pbd_pkg::ST_MISALIGNED;
         end
      end
      item_in        = '0;
      item_in.status = status;
      if (status == pbd_pkg::ST_OK) begin
         item_in.region_kind  = in_stage.kind;
         item_in.prefetch     = in_stage.prefetch;
         item_in.slots_used   = in_stage.slots;
         item_in.base_address = in_stage.base;
         item_in.region_size  = in_stage.size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_stage.valid;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: tb/tb_pci_bar_decode_top.sv
// testbench for the pci base address register decoder, checked against a built-in predictor
`timescale 1ns / 1ps

module tb_pci_bar_decode_top;
   import pbd_pkg::*;

   // watchdog: cycles in a row with neither an item taken nor a result seen
   localparam int unsigned STALL_LIMIT = 500;
   // once the last result is back, settle a little longer at the end
   localparam int unsigned SETTLE_CYCLES = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   rsp_type     pending_decodes[$];   // predicted decodes, oldest first
   rsp_type     oldest_decode;
   int unsigned error_count  = 0;
   int unsigned stall_cycles = 0;
   bit          idle_on      = 1'b1;   // random start gaps enabled

   pci_bar_decode_top DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // predictor: decode one bar slot the way the hardware should
   // ---------------------------------------------------------------

   // error result: only status survives, every other field is zero
   function automatic rsp_type bar_error(logic [2:0] code);
      rsp_type d;
      d        = '0;
      d.status = code;
      return d;
   endfunction

   function automatic rsp_type decode_bar(req_type r);
      rsp_type     d;
      logic [31:0] io_mask;
      logic [31:0] mem_type;
      logic [31:0] size32;
      logic [63:0] mask;
      logic [63:0] base;
      logic [63:0] size;
      logic [1:0]  kind;
      logic        pf;
      logic [1:0]  slots;
      pf    = 1'b0;
      slots = 2'd1;
      if (r.bar_index >= NUM_SLOTS) return bar_error(ST_BAD_INDEX);
      if ((r.orig_low & IO_BIT) != '0) begin
         // io space; a mask with a blank upper half is a 16-bit decoder
         io_mask = r.probed_low & IO_ADDR_BITS;
         if ((io_mask & IO_UPPER_HALF) == '0) io_mask = io_mask | IO_UPPER_HALF;
         kind = KIND_IO;
         mask = {32'h0, io_mask};
         base = {32'h0, r.orig_low & IO_ADDR_BITS};
      end else begin
         mem_type = r.orig_low & MEM_TYPE_FIELD;
         pf       = (r.orig_low & PREFETCH_BIT) != '0;
         if (mem_type == '0) begin
            kind = KIND_MEM32;
            mask = {32'h0, r.probed_low & MEM_ADDR_BITS};
            base = {32'h0, r.orig_low & MEM_ADDR_BITS};
         end else if (mem_type == MEM_TYPE_64) begin
            // a 64-bit bar needs the next slot too
            if (r.bar_index + 1 >= NUM_SLOTS) return bar_error(ST_UNSUPPORTED);
            kind  = KIND_MEM64;
            slots = 2'd2;
            mask  = {r.probed_high, r.probed_low & MEM_ADDR_BITS};
            base  = {r.orig_high, r.orig_low & MEM_ADDR_BITS};
         end else begin
            return bar_error(ST_UNSUPPORTED);
         end
      end
      if (mask == '0) return bar_error(ST_UNIMPLEMENTED);
      // size is the two's complement of the mask, 32 bits wide except for 64-bit memory
      if (kind == KIND_MEM64) begin
         size = ~mask + 64'd1;
      end else begin
         size32 = ~mask[31:0] + 32'd1;
         size   = {32'h0, size32};
      end
      if (size == '0 || (size & (size - 64'd1)) != '0) return bar_error(ST_BAD_SIZE);
      if (kind == KIND_IO && size < IO_MIN_SIZE) return bar_error(ST_BAD_SIZE);
      if (kind != KIND_IO && size < MEM_MIN_SIZE) return bar_error(ST_BAD_SIZE);
      if (base == '0) return bar_error(ST_UNASSIGNED);
      if ((base & (size - 64'd1)) != '0) return bar_error(ST_MISALIGNED);
      d.status       = ST_OK;
      d.region_kind  = kind;
      d.prefetch     = pf;
      d.slots_used   = slots;
      d.base_address = base;
      d.region_size  = size;
      return d;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic req_type make_bar(logic [2:0] idx, logic [31:0] olo, logic [31:0] ohi,
                                        logic [31:0] plo, logic [31:0] phi);
      req_type r;
      r.bar_index   = idx;
      r.orig_low    = olo;
      r.orig_high   = ohi;
      r.probed_low  = plo;
      r.probed_high = phi;
      return r;
   endfunction

   function automatic req_type random_bar();
      return make_bar(3'($urandom_range(0, 7)), $urandom(), $urandom(), $urandom(), $urandom());
   endfunction

   // a slot as real hardware would present it: power-of-two mask, aligned base,
   // with now and then a misaligned or zero base, a bad index or a damaged mask
   function automatic req_type well_formed_bar();
      req_type     r;
      int unsigned pick;
      int unsigned e;
      int unsigned low_bit;
      int unsigned top_bit;
      logic [63:0] m64;
      logic [63:0] b64;
      logic        pf;
      r       = random_bar();
      pick    = $urandom_range(0, 2);
      low_bit = (pick == 0) ? 2 : 4;
      top_bit = (pick == 2) ? 63 : 31;
      // mostly small regions, sometimes anything up to the widest
      if ($urandom_range(0, 3) == 0) e = $urandom_range(low_bit, top_bit);
      else e = $urandom_range(low_bit, low_bit + 8);
      m64 = ~((64'd1 << e) - 64'd1);
      b64 = {$urandom(), $urandom()} & m64;
      pf  = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 5 && e > low_bit)
         b64 = b64 ^ (64'd1 << $urandom_range(low_bit, e - 1));
      if ($urandom_range(0, 99) < 4) b64 = '0;
      if ($urandom_range(0, 99) < 6) r.bar_index = 3'($urandom_range(5, 7));
      else r.bar_index = 3'($urandom_range(0, (pick == 2) ? 4 : 5));
      case (pick)
         0: begin
            r.orig_low   = (b64[31:0] & IO_ADDR_BITS) | IO_BIT
                           | ($urandom() & ~(IO_ADDR_BITS | IO_BIT));
            r.probed_low = m64[31:0] | IO_BIT | ($urandom() & ~(IO_ADDR_BITS | IO_BIT));
            // 16-bit io decoder: upper half reads back as zero
            if (e <= 16 && $urandom_range(0, 3) == 0)
               r.probed_low = r.probed_low & ~IO_UPPER_HALF;
         end
         1: begin
            r.orig_low   = b64[31:0] | (pf ? PREFETCH_BIT : '0);
            r.probed_low = m64[31:0] | (r.orig_low & ~MEM_ADDR_BITS);
         end
         default: begin
            r.orig_low    = b64[31:0] | MEM_TYPE_64 | (pf ? PREFETCH_BIT : '0);
            r.orig_high   = b64[63:32];
            r.probed_low  = m64[31:0] | (r.orig_low & ~MEM_ADDR_BITS);
            r.probed_high = m64[63:32];
         end
      endcase
      if ($urandom_range(0, 99) < 5)
         r.probed_low = r.probed_low ^ (32'd1 << $urandom_range(0, 31));
      if ($urandom_range(0, 99) < 3)
         r.probed_high = r.probed_high ^ (32'd1 << $urandom_range(0, 31));
      return r;
   endfunction

   // hand one item to the decoder; returns at the edge that takes it
   task automatic send_bar(input req_type bar);
      int unsigned gap;
      if (idle_on && $urandom_range(0, 99) < 7) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            start    <= 1'b0;
            req_item <= random_bar();   // junk while start is low
         end
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= bar;
      do @(posedge clock); while (busy);
      pending_decodes.push_back(decode_bar(bar));
   endtask

   // stop sending and wait for every predicted decode to come back
   task automatic wait_for_drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // field extremes, every region kind and every error code
   task automatic test_directed_cases();
      send_bar(make_bar(3'd6, 32'h0000_1001, '0, 32'hFFFF_FF01, '0));            // index 6
      send_bar(make_bar(3'd7, '1, '1, '1, '1));                                  // index 7
      send_bar(make_bar(3'd0, 32'h0000_1001, '0, 32'hFFFF_FF01, '0));            // io ok
      send_bar(make_bar(3'd1, 32'h0000_E001, '0, 32'h0000_FFE1, '0));            // 16-bit io
      send_bar(make_bar(3'd2, 32'h0000_0105, '0, 32'hFFFF_FFFD, '0));            // io size 4
      send_bar(make_bar(3'd3, 32'h0000_1001, '0, 32'hFFFF_00F1, '0));            // io bad size
      send_bar(make_bar(3'd0, 32'h0000_0003, '0, 32'hFFFF_FF01, '0));            // io base zero
      send_bar(make_bar(3'd0, 32'h0000_1041, '0, 32'hFFFF_FF01, '0));            // io misaligned
      send_bar(make_bar(3'd0, 32'hFEB0_0000, '0, 32'hFFF0_0000, '0));            // mem32 ok
      send_bar(make_bar(3'd4, 32'hE000_0008, '0, 32'hF000_0008, '0));            // prefetch
      send_bar(make_bar(3'd5, 32'h0000_0010, '0, 32'hFFFF_FFF0, '0));            // size 16
      send_bar(make_bar(3'd1, 32'h8000_0000, '0, 32'h8000_0000, '0));            // 2 gb
      send_bar(make_bar(3'd0, '0, '0, '0, '0));                                  // no mask
      send_bar(make_bar(3'd0, 32'hF000_0002, '0, 32'hFFF0_0002, '0));            // type 1
      send_bar(make_bar(3'd2, 32'hF000_000E, '0, 32'hFFF0_000E, '0));            // type 3
      send_bar(make_bar(3'd0, 32'h0000_000C, 32'h1, 32'hFFF0_000C, '1));         // mem64 ok
      send_bar(make_bar(3'd5, 32'h0000_0004, 32'h1, 32'hFFF0_0004, '1));         // mem64 last
      send_bar(make_bar(3'd3, 32'h1000_0004, '0, 32'h0000_0004, '0));            // mem64 no mask
      send_bar(make_bar(3'd0, 32'h0000_0004, 32'h8000_0000, '0, 32'h8000_0000)); // widest
      send_bar(make_bar(3'd1, 32'h0000_0004, 32'h4000_0000, '0, 32'h8000_0000)); // high misalign
      send_bar(make_bar(3'd2, 32'h0000_0004, 32'h1, 32'hFFF0_0000, 32'hFFFF_0FFF));
      send_bar(make_bar(3'd0, 32'h0000_0008, '0, 32'hFFFF_F000, '0));            // mem base zero
      send_bar(make_bar(3'd0, 32'h0000_1000, '0, 32'hFFFF_0000, '0));            // mem misaligned
      send_bar(make_bar(3'd0, '1, '1, '1, '1));                                  // all ones
   endtask

   task automatic test_well_formed(input int unsigned count);
      repeat (count) send_bar(well_formed_bar());
   endtask

   task automatic test_noise(input int unsigned count);
      repeat (count) send_bar(random_bar());
   endtask

   // back to back items with no gaps at all
   task automatic test_burst(input int unsigned count);
      idle_on = 1'b0;
      repeat (count) send_bar(well_formed_bar());
      idle_on = 1'b1;
   endtask

   // sender holds off until the pipeline is empty, several times over
   task automatic test_drain_pauses();
      repeat (4) begin
         repeat ($urandom_range(5, 30)) send_bar(well_formed_bar());
         wait_for_drain();
      end
   endtask

   // ---------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
   endtask

   // every strobe is one result; compare it with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_decodes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none actual %h", $time, rsp_item);
         end else begin
            oldest_decode = pending_decodes.pop_front();
            check_field("status", 64'(oldest_decode.status), 64'(rsp_item.status));
            check_field("region_kind", 64'(oldest_decode.region_kind), 64'(rsp_item.region_kind));
            check_field("prefetch", 64'(oldest_decode.prefetch), 64'(rsp_item.prefetch));
            check_field("slots_used", 64'(oldest_decode.slots_used), 64'(rsp_item.slots_used));
            check_field("base_address", oldest_decode.base_address, rsp_item.base_address);
            check_field("region_size", oldest_decode.region_size, rsp_item.region_size);
         end
      end
   end

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------
   initial begin
      // reset held from time zero, released on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_well_formed(600);
      test_drain_pauses();
      test_burst(250);
      test_noise(250);
      test_well_formed(300);

      // let the pipeline empty, then wait on for stray strobes
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/pbd_pkg.sv
hdl/pbd_classify.sv
hdl/pbd_size.sv
hdl/pbd_check.sv
hdl/pci_bar_decode_top.sv
tb/tb_pci_bar_decode_top.sv
